### rtl/arp_pkg.sv
// Package for the AArch64 relocation patcher: word types, relocation codes,
// entry classes and result codes. No dependencies.
package arp_pkg;

  // Relocation type numbers.
  localparam logic [31:0] RT_NONE_ARM = 32'd0;
  localparam logic [31:0] RT_NONE     = 32'd256;
  localparam logic [31:0] RT_ABS64    = 32'd257;
  localparam logic [31:0] RT_ABS32    = 32'd258;
  localparam logic [31:0] RT_ABS16    = 32'd259;
  localparam logic [31:0] RT_PREL64   = 32'd260;
  localparam logic [31:0] RT_PREL32   = 32'd261;
  localparam logic [31:0] RT_PREL16   = 32'd262;
  localparam logic [31:0] RT_JUMP26   = 32'd282;
  localparam logic [31:0] RT_CALL26   = 32'd283;

  // Store widths.
  localparam logic [1:0] SZ_NONE = 2'd0;
  localparam logic [1:0] SZ_2    = 2'd1;
  localparam logic [1:0] SZ_4    = 2'd2;
  localparam logic [1:0] SZ_8    = 2'd3;

  // Status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_UNSUP = 2'd2;

  // Field of the instruction word that a branch patch replaces.
  localparam logic [31:0] IMM26_MASK = 32'h03ff_ffff;

  typedef enum logic [3:0] {
    CL_NONE,
    CL_ABS64,
    CL_ABS32,
    CL_ABS16,
    CL_PREL64,
    CL_PREL32,
    CL_PREL16,
    CL_BRANCH,
    CL_UNSUP
  } rel_class_e;

  typedef struct packed {
    logic [31:0] reloc_type;
    logic [63:0] sym_value;
    logic signed [63:0] addend;
    logic [63:0] place_address;
    logic [31:0] old_word;
  } in_word_t;

  typedef struct packed {
    logic [63:0] new_value;
    logic [1:0]  write_size;
    logic [1:0]  status;
  } out_word_t;

  // One classified entry as it waits between front and back.
  typedef struct packed {
    rel_class_e  cls;
    logic [63:0] value;
    logic [63:0] place;
    logic [31:0] old_word;
  } arp_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } arp_q_status_t;

endpackage

### rtl/arp_front.sv
// Front end of the relocation patcher: decodes the type into a class and
// forms symbol plus addend. Depends on arp_pkg.
module arp_front import arp_pkg::*; (
  input  in_word_t   word_i,
  output arp_entry_t entry_o
);

  rel_class_e cls;

  always_comb begin
    unique case (word_i.reloc_type) inside
      RT_NONE_ARM, RT_NONE:  cls = CL_NONE;
      RT_ABS64:              cls = CL_ABS64;
      RT_ABS32:              cls = CL_ABS32;
      RT_ABS16:              cls = CL_ABS16;
      RT_PREL64:             cls = CL_PREL64;
      RT_PREL32:             cls = CL_PREL32;
      RT_PREL16:             cls = CL_PREL16;
      RT_JUMP26, RT_CALL26:  cls = CL_BRANCH;
      default:               cls = CL_UNSUP;
    endcase
  end

  assign entry_o.cls      = cls;
  assign entry_o.value    = word_i.sym_value + $unsigned(word_i.addend);
  assign entry_o.place    = word_i.place_address;
  assign entry_o.old_word = word_i.old_word;

endmodule

### rtl/arp_queue.sv
// Short queue of classified entries between front and back end.
// Depends on arp_pkg.
module arp_queue import arp_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  arp_entry_t    entry_i,
  input  logic          pop_i,
  output arp_entry_t    entry_o,
  output arp_q_status_t status_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  arp_entry_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic do_push, do_pop;

  assign status_o.full  = (count_q == FullCnt);
  assign status_o.empty = (count_q == '0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign entry_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

### rtl/arp_back.sv
// Back end of the relocation patcher: forms value minus place, checks the
// range for the class and registers the result word. Depends on arp_pkg.
module arp_back import arp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  arp_entry_t entry_i,
  output logic       done_o,
  output out_word_t  result_o
);

  logic [63:0] diff;
  logic abs32_bad, abs16_bad, prel32_bad, prel16_bad, br_bad;
  out_word_t res_d, res_q;
  logic done_q;

  assign diff = entry_i.value - entry_i.place;

  // A signed range check holds when all bits above the field agree.
  assign abs32_bad  = (entry_i.value[63:32] != '0);
  assign abs16_bad  = (entry_i.value[63:16] != '0);
  assign prel32_bad = !((diff[63:31] == '0) || (diff[63:31] == '1));
  assign prel16_bad = !((diff[63:15] == '0) || (diff[63:15] == '1));
  assign br_bad     = !((diff[63:27] == '0) || (diff[63:27] == '1));

  always_comb begin
    res_d = '{new_value: '0, write_size: SZ_NONE, status: ST_OK};
    unique case (entry_i.cls)
      CL_NONE: begin
        res_d = '{new_value: '0, write_size: SZ_NONE, status: ST_OK};
      end
      CL_ABS64: begin
        res_d = '{new_value: entry_i.value, write_size: SZ_8, status: ST_OK};
      end
      CL_PREL64: begin
        res_d = '{new_value: diff, write_size: SZ_8, status: ST_OK};
      end
      CL_ABS32: begin
        res_d.new_value  = {32'd0, entry_i.value[31:0]};
        res_d.write_size = SZ_4;
        res_d.status     = abs32_bad ? ST_RANGE : ST_OK;
      end
      CL_PREL32: begin
        res_d.new_value  = {32'd0, diff[31:0]};
        res_d.write_size = SZ_4;
        res_d.status     = prel32_bad ? ST_RANGE : ST_OK;
      end
      CL_ABS16: begin
        res_d.new_value  = {48'd0, entry_i.value[15:0]};
        res_d.write_size = SZ_2;
        res_d.status     = abs16_bad ? ST_RANGE : ST_OK;
      end
      CL_PREL16: begin
        res_d.new_value  = {48'd0, diff[15:0]};
        res_d.write_size = SZ_2;
        res_d.status     = prel16_bad ? ST_RANGE : ST_OK;
      end
      CL_BRANCH: begin
        if (br_bad) begin
          res_d = '{new_value: '0, write_size: SZ_NONE, status: ST_RANGE};
        end else begin
          res_d.new_value  = {32'd0, (entry_i.old_word & ~IMM26_MASK) |
                                     ({6'd0, diff[27:2]} & IMM26_MASK)};
          res_d.write_size = SZ_4;
          res_d.status     = ST_OK;
        end
      end
      default: begin
        res_d = '{new_value: '0, write_size: SZ_NONE, status: ST_UNSUP};
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_i;
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

### rtl/aarch64_relocation_patcher_top.sv
// Top level of the AArch64 relocation patcher: front end, entry queue and
// back end. Depends on arp_pkg, arp_front, arp_queue and arp_back.
//
//   Channel   Signals                   Handshake
//   -------   -----------------------   ------------------------------------
//   input     start_i, word_i           word taken when start_i && !busy_o
//   result    done_o, result_o          word valid for one cycle on done_o
//
// A word taken at one edge is decoded and has symbol plus addend formed
// before it lands in the queue; the back end reads the queue head, forms
// value minus place and the range checks, and registers the result. The
// word thus passes the queue and the back end's result register before
// done_o rises; one word can be taken every cycle while busy_o is low. The
// back end drains one entry per cycle and the receiver cannot stall, so the
// queue never fills in practice and busy_o stays low; it still guards
// against overrun. Reset empties the queue and clears done_o.
module aarch64_relocation_patcher_top import arp_pkg::*; #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  in_word_t  word_i,
  output logic      busy_o,
  output logic      done_o,
  output out_word_t result_o
);

  arp_entry_t    front_entry;
  arp_entry_t    head_entry;
  arp_q_status_t q_status;
  logic          accept;
  logic          head_valid;

  // The queue full flag is the only thing that holds new words off.
  assign busy_o     = q_status.full;
  assign accept     = start_i && !q_status.full;
  assign head_valid = !q_status.empty;

  arp_front u_front (
    .word_i  (word_i),
    .entry_o (front_entry)
  );

  arp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (accept),
    .entry_i  (front_entry),
    .pop_i    (head_valid),
    .entry_o  (head_entry),
    .status_o (q_status)
  );

  // The back end takes the head word whenever there is one.
  arp_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (head_valid),
    .entry_i  (head_entry),
    .done_o   (done_o),
    .result_o (result_o)
  );

endmodule

### bench/reloc_result_checker.sv
// Result checker for the AArch64 relocation patcher: predicts each word's
// result from the accepted input words and compares the result words.
// Depends on arp_pkg.
`timescale 1ns / 1ps

module reloc_result_checker import arp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  logic      busy_i,
  input  in_word_t  word_i,
  input  logic      done_i,
  input  out_word_t result_i,
  output int        fail_count_o,
  output int        pending_o
);

  localparam int unsigned ReportLimit = 10;

  // Branch range is [-2^25, 2^25 - 1] after the shift; biasing by 2^25 makes
  // it one unsigned compare.
  localparam logic [63:0] BranchBias  = 64'h0000_0000_0200_0000;
  localparam logic [63:0] BranchSpan  = 64'h0000_0000_0400_0000;
  localparam logic [63:0] Max32       = 64'h0000_0000_ffff_ffff;
  localparam logic [63:0] Max16       = 64'h0000_0000_0000_ffff;
  localparam logic [63:0] Bias32      = 64'h0000_0000_8000_0000;
  localparam logic [63:0] Bias16      = 64'h0000_0000_0000_8000;

  out_word_t patch_q[$];

  function automatic out_word_t predict_patch(in_word_t w);
    logic [63:0] sum;
    logic [63:0] diff;
    logic [63:0] shifted;
    out_word_t   r;
    sum     = w.sym_value + w.addend;
    diff    = sum - w.place_address;
    shifted = {{2{diff[63]}}, diff[63:2]};
    r.new_value  = '0;
    r.write_size = SZ_NONE;
    r.status     = ST_OK;
    case (w.reloc_type)
      RT_NONE_ARM, RT_NONE: begin
      end
      RT_ABS64: begin
        r.new_value  = sum;
        r.write_size = SZ_8;
      end
      RT_PREL64: begin
        r.new_value  = diff;
        r.write_size = SZ_8;
      end
      RT_ABS32: begin
        r.new_value  = {32'b0, sum[31:0]};
        r.write_size = SZ_4;
        if (sum > Max32) r.status = ST_RANGE;
      end
      RT_PREL32: begin
        r.new_value  = {32'b0, diff[31:0]};
        r.write_size = SZ_4;
        if (diff + Bias32 > Max32) r.status = ST_RANGE;
      end
      RT_ABS16: begin
        r.new_value  = {48'b0, sum[15:0]};
        r.write_size = SZ_2;
        if (sum > Max16) r.status = ST_RANGE;
      end
      RT_PREL16: begin
        r.new_value  = {48'b0, diff[15:0]};
        r.write_size = SZ_2;
        if (diff + Bias16 > Max16) r.status = ST_RANGE;
      end
      RT_JUMP26, RT_CALL26: begin
        if (shifted + BranchBias >= BranchSpan) begin
          r.status = ST_RANGE;
        end else begin
          r.new_value  = {32'b0, (w.old_word & ~IMM26_MASK) | (shifted[31:0] & IMM26_MASK)};
          r.write_size = SZ_4;
        end
      end
      default: begin
        r.status = ST_UNSUP;
      end
    endcase
    return r;
  endfunction

  // A result is taken only after its word has passed the queue and the result
  // register, so at any edge the result belongs to an older word than the one being taken.
  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t want;
    if (!rst_ni) begin
      patch_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (done_i) begin
        if (patch_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= ReportLimit)
            $display("%0t: unexpected result word %h", $realtime, result_i);
        end else begin
          want = patch_q.pop_front();
          if (result_i.new_value !== want.new_value ||
              result_i.write_size !== want.write_size ||
              result_i.status !== want.status) begin
            fail_count_o++;
            if (fail_count_o <= ReportLimit)
              $display({"%0t: mismatch: expected value %h size %0d status %0d, ",
                        "got value %h size %0d status %0d"},
                       $realtime, want.new_value, want.write_size, want.status,
                       result_i.new_value, result_i.write_size, result_i.status);
          end
        end
      end
      if (start_i && !busy_i) patch_q.push_back(predict_patch(word_i));
      pending_o = patch_q.size();
    end
  end

endmodule

### bench/testbench.sv
// Top of the bench for the AArch64 relocation patcher: clock, reset, input
// words and verdict. Depends on arp_pkg, aarch64_relocation_patcher_top and
// reloc_result_checker.
`timescale 1ns / 1ps

module testbench;
  import arp_pkg::*;

  // The bound lies far above the slowest correct run (every word waiting out
  // the longest gap), so it only catches a hang.
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned RandomWords = 1850;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      start_i;
  in_word_t  word_i;
  logic      busy_o;
  logic      done_o;
  out_word_t result_o;

  int fail_count;
  int pending;
  int unsigned cycle_count;
  bit burst_mode;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  aarch64_relocation_patcher_top u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .word_i  (word_i),
    .busy_o  (busy_o),
    .done_o  (done_o),
    .result_o(result_o)
  );

  // The checker sees exactly what the block sees and keeps its own queue of
  // predicted results; the top only needs its counts.
  reloc_result_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_i      (busy_o),
    .word_i      (word_i),
    .done_i      (done_o),
    .result_i    (result_o),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // Watchdog. Anything that stalls the run past the bound counts as a failure.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Most gaps are zero or short; a few are long enough to let the pipeline
  // empty completely. Burst stretches force back-to-back words.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (burst_mode || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // Offsets that make a sum or difference land where the range checks bite:
  // values of every magnitude, of either sign, and values right at the edges
  // of the 16-bit, 32-bit and branch ranges.
  function automatic logic [63:0] shaped_offset();
    logic [63:0] edge_val;
    logic [63:0] v;
    case ($urandom_range(0, 2))
      0: v = rand64() & ((64'd1 << $urandom_range(0, 63)) - 64'd1);
      1: v = -(rand64() & ((64'd1 << $urandom_range(0, 63)) - 64'd1));
      default: begin
        case ($urandom_range(0, 4))
          0:       edge_val = 64'h0000_0000_0000_8000;
          1:       edge_val = 64'h0000_0000_0001_0000;
          2:       edge_val = 64'h0000_0000_8000_0000;
          3:       edge_val = 64'h0000_0001_0000_0000;
          default: edge_val = 64'h0000_0000_0800_0000;
        endcase
        v = edge_val + $urandom_range(0, 7) - 64'd4;
        if ($urandom_range(0, 1)) v = -v;
      end
    endcase
    return v;
  endfunction

  // Presents one word and holds it until the block takes it. With no gap it returns
  // on the falling edge after the taking edge, with start_i still high, so the next
  // word can follow without a bubble; else it drops start_i for the gap first.
  task automatic send_word(in_word_t w);
    int unsigned gap;
    start_i <= 1'b1;
    word_i  <= w;
    do @(posedge clk_i); while (busy_o);
    @(negedge clk_i);
    gap = pick_gap();
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic send_entry(logic [31:0] rtype, logic [63:0] sym, logic [63:0] add,
                            logic [63:0] place, logic [31:0] old);
    in_word_t w;
    w.reloc_type    = rtype;
    w.sym_value     = sym;
    w.addend        = add;
    w.place_address = place;
    w.old_word      = old;
    send_word(w);
  endtask

  // Absolute entry whose symbol plus addend equals the given value.
  task automatic send_abs(logic [31:0] rtype, logic [63:0] val);
    logic [63:0] add;
    add = rand64();
    send_entry(rtype, val - add, add, rand64(), $urandom);
  endtask

  // Relative entry whose value minus place equals the given difference.
  task automatic send_rel(logic [31:0] rtype, logic [63:0] diff, logic [31:0] old);
    logic [63:0] add;
    logic [63:0] place;
    add   = rand64();
    place = rand64();
    send_entry(rtype, place + diff - add, add, place, old);
  endtask

  // Stops sending until every predicted result has come back.
  task automatic drain_results();
    start_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  function automatic logic [31:0] pick_type();
    case ($urandom_range(0, 12))
      0:  return $urandom_range(0, 1) ? RT_NONE : RT_NONE_ARM;
      1:  return RT_ABS64;
      2:  return RT_ABS32;
      3:  return RT_ABS16;
      4:  return RT_PREL64;
      5:  return RT_PREL32;
      6:  return RT_PREL16;
      7:  return RT_JUMP26;
      8:  return RT_CALL26;
      9:  return RT_JUMP26;
      10: return RT_CALL26;
      // Mostly unsupported numbers: some near the supported block, some anywhere.
      11: return $urandom_range(1, 300);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random_word();
    logic [31:0] rtype;
    rtype = pick_type();
    case ($urandom_range(0, 6))
      // Fully random fields: overflow almost always, but every bit toggles.
      0: send_entry(rtype, rand64(), rand64(), rand64(), $urandom);
      1, 2: send_abs(rtype, shaped_offset());
      default: send_rel(rtype, shaped_offset(), $urandom);
    endcase
  endtask

  initial begin
    start_i    = 1'b0;
    word_i     = '0;
    rst_ni     = 1'b0;
    burst_mode = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Null relocations carry junk in every other field.
    send_entry(RT_NONE_ARM, '1, '1, '1, '1);
    send_entry(RT_NONE, '1, '1, '1, '1);
    // 64-bit data wraps instead of overflowing.
    send_entry(RT_ABS64, '1, 64'd1, '0, '0);
    send_entry(RT_PREL64, '0, '0, '1, '0);
    // Absolute 32 and 16: top of range and one past it, and a negative value for 32.
    send_abs(RT_ABS32, 64'h0000_0000_ffff_ffff);
    send_abs(RT_ABS32, 64'h0000_0001_0000_0000);
    send_abs(RT_ABS32, '1);
    send_abs(RT_ABS16, 64'h0000_0000_0000_ffff);
    send_abs(RT_ABS16, 64'h0000_0000_0001_0000);
    // Relative 32 and 16: both signed limits and one beyond each.
    send_rel(RT_PREL32, 64'h0000_0000_7fff_ffff, '0);
    send_rel(RT_PREL32, 64'h0000_0000_8000_0000, '0);
    send_rel(RT_PREL32, 64'hffff_ffff_8000_0000, '0);
    send_rel(RT_PREL32, 64'hffff_ffff_7fff_ffff, '0);
    send_rel(RT_PREL16, 64'h0000_0000_0000_7fff, '0);
    send_rel(RT_PREL16, 64'h0000_0000_0000_8000, '0);
    send_rel(RT_PREL16, 64'hffff_ffff_ffff_8000, '0);
    send_rel(RT_PREL16, 64'hffff_ffff_ffff_7fff, '0);
    // Branches: farthest forward and backward targets, one step beyond each,
    // and an unaligned backward difference that rounds down to -1.
    send_rel(RT_JUMP26, 64'h0000_0000_07ff_fffc, '1);
    send_rel(RT_JUMP26, 64'h0000_0000_0800_0000, '1);
    send_rel(RT_CALL26, 64'hffff_ffff_f800_0000, '0);
    send_rel(RT_CALL26, 64'hffff_ffff_f7ff_fffc, '0);
    send_rel(RT_JUMP26, '1, $urandom);
    // Unsupported type numbers around and far from the known ones.
    send_entry(32'd1, rand64(), rand64(), rand64(), $urandom);
    send_entry(32'd281, rand64(), rand64(), rand64(), $urandom);
    send_entry(32'hffff_ffff, rand64(), rand64(), rand64(), $urandom);

    drain_results();

    for (int unsigned n = 0; n < RandomWords; n++) begin
      // Every 200 words, one time in three, run a stretch with no gaps at all.
      if (n % 200 == 0) burst_mode = ($urandom_range(0, 2) == 0);
      if (n == RandomWords / 2) drain_results();
      send_random_word();
    end

    drain_results();
    repeat (8) @(negedge clk_i);

    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
